@@ design/assert_macros.svh @@
// Assertion macros shared by the request queue RTL.
// Needs nothing else; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RQF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define RQF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `RQF_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define RQF_ASSERT(lbl, clk, rst_n, prop)
`define RQF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/rqf_pkg.sv @@
// Package for the request queue: sizes, operation and status codes, cell control.
// Used by rqf_cell and request_fifo_with_cancel_core; depends on nothing.
package rqf_pkg;

  localparam int Depth     = 16;
  localparam int PosW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW      = $clog2(Depth + 1);
  localparam int ModeW     = 3;
  localparam int IdW       = 16;
  localparam int StampW    = 32;
  localparam int PosFieldW = 4;
  localparam int CntFieldW = 5;
  localparam int StatusW   = 3;

  typedef enum logic [ModeW-1:0] {
    ModePush      = 3'd0,
    ModePop       = 3'd1,
    ModeRemoveId  = 3'd2,
    ModeFindId    = 3'd3,
    ModeRemovePos = 3'd4,
    ModePeek      = 3'd5
  } rqf_mode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 3'd0,
    StatusEmpty    = 3'd1,
    StatusNotFound = 3'd2,
    StatusFull     = 3'd3,
    StatusRange    = 3'd4
  } rqf_status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } rqf_state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } rqf_cell_ctrl_t;

endpackage

@@ design/rqf_cell.sv @@
// One queue cell: holds an id and its arrival stamp, compares the id with a key.
// Depends on rqf_pkg; its neighbour towards the tail feeds it on a shift.
module rqf_cell import rqf_pkg::*; (
  input  logic              clk_i,
  input  rqf_cell_ctrl_t    ctrl_i,
  input  logic [IdW-1:0]    key_i,
  input  logic [IdW-1:0]    push_id_i,
  input  logic [StampW-1:0] push_stamp_i,
  input  logic [IdW-1:0]    next_id_i,
  input  logic [StampW-1:0] next_stamp_i,
  output logic [IdW-1:0]    id_o,
  output logic [StampW-1:0] stamp_o,
  output logic              match_o
);

  logic [IdW-1:0]    id_q, id_d;
  logic [StampW-1:0] stamp_q, stamp_d;

  always_comb begin
    id_d    = id_q;
    stamp_d = stamp_q;
    if (ctrl_i.shift) begin
      id_d    = next_id_i;
      stamp_d = next_stamp_i;
    end else if (ctrl_i.load) begin
      id_d    = push_id_i;
      stamp_d = push_stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    stamp_q <= stamp_d;
  end

  assign id_o    = id_q;
  assign stamp_o = stamp_q;
  assign match_o = (id_q == key_i);

endmodule

@@ design/request_fifo_with_cancel_core.sv @@
// Ordered request queue with removal by id or position: a row of rqf_cell.
// Depends on rqf_pkg, rqf_cell and assert_macros.svh.
//
// Usage: an input transaction (mode, req_id, arrival_stamp, position) is taken
// on in_valid_i/in_ready_o and yields exactly one result transaction (status,
// out_id, out_stamp, out_position, entry_count, is_empty) on
// out_valid_o/out_ready_i. Entries are held oldest first, one per cell.
// Timing: at the accepting edge every cell compares its id with req_id_i and
// the hits of occupied cells are registered. In the execute state a priority
// encoder picks the oldest hit, one read mux fetches the entry, and the cells
// at and above the removed slot take their tail-side neighbour's contents, so
// the gap closes at the executing edge. The result is written to the output
// register at that edge; a new transaction is taken only after the last executes.
// While the receiver stalls, the result is held and one further transaction
// may be accepted; its execution waits until the output register is free.
// Reset empties the queue (occupancy zero), drops the result valid and leaves
// the input ready; the cell contents are left as they are and never read until
// written.
`include "assert_macros.svh"

module request_fifo_with_cancel_core import rqf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ModeW-1:0]     mode_i,
  input  logic [IdW-1:0]       req_id_i,
  input  logic [StampW-1:0]    arrival_stamp_i,
  input  logic [PosFieldW-1:0] position_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [StatusW-1:0]   status_o,
  output logic [IdW-1:0]       out_id_o,
  output logic [StampW-1:0]    out_stamp_o,
  output logic [PosFieldW-1:0] out_position_o,
  output logic [CntFieldW-1:0] entry_count_o,
  output logic                 is_empty_o
);

  rqf_state_e state_q, state_d;
  logic in_fire, exec_fire;

  logic [ModeW-1:0]     req_mode_q;
  logic [IdW-1:0]       req_id_q;
  logic [StampW-1:0]    req_stamp_q;
  logic [PosFieldW-1:0] req_pos_q;
  logic [Depth-1:0]     hit_q, hit_d;
  logic [CntW-1:0]      count_q, count_d;

  logic [IdW-1:0]    cell_id    [Depth];
  logic [StampW-1:0] cell_stamp [Depth];
  logic [Depth-1:0]  cell_match;
  rqf_cell_ctrl_t    cell_ctrl  [Depth];

  logic                out_valid_q;
  logic [StatusW-1:0]  out_status_q;
  logic [IdW-1:0]      out_id_q;
  logic [StampW-1:0]   out_stamp_q;
  logic [PosFieldW-1:0] out_pos_q;
  logic [CntW-1:0]     out_count_q;

  // Execution datapath
  logic [PosW-1:0]    hit_pos, rd_idx, rm_idx, r_pos;
  logic               hit_any, pos_ok, is_full, is_none;
  logic               do_push, do_remove;
  logic [StatusW-1:0] st;
  logic [IdW-1:0]     r_id;
  logic [StampW-1:0]  r_stamp;

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [IdW-1:0]    nb_id;
    logic [StampW-1:0] nb_stamp;

    if (g == Depth - 1) begin : g_last
      assign nb_id    = '0;
      assign nb_stamp = '0;
    end else begin : g_mid
      assign nb_id    = cell_id[g+1];
      assign nb_stamp = cell_stamp[g+1];
    end

    rqf_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[g]),
      .key_i        (req_id_i),
      .push_id_i    (req_id_q),
      .push_stamp_i (req_stamp_q),
      .next_id_i    (nb_id),
      .next_stamp_i (nb_stamp),
      .id_o         (cell_id[g]),
      .stamp_o      (cell_stamp[g]),
      .match_o      (cell_match[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StExec;
      StExec:  if (exec_fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == StIdle);
    exec_fire  = (state_q == StExec) && (!out_valid_q || out_ready_i);
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Only occupied cells may report a hit.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      hit_d[i] = cell_match[i] && (CntW'(i) < count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Execution
  // ---------------------------------------------------------------------------
  always_comb begin
    hit_pos = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hit_q[i]) hit_pos = PosW'(i);
    end
  end

  assign hit_any = |hit_q;
  assign pos_ok  = (32'(req_pos_q) < 32'(count_q));
  assign is_full = (count_q == CntW'(Depth));
  assign is_none = (count_q == '0);

  always_comb begin
    st        = StatusOk;
    rd_idx    = '0;
    r_pos     = '0;
    do_push   = 1'b0;
    do_remove = 1'b0;
    case (req_mode_q)
      ModePush: begin
        if (is_full) begin
          st = StatusFull;
        end else begin
          do_push = 1'b1;
          r_pos   = PosW'(count_q);
        end
      end
      ModePop, ModePeek: begin
        if (is_none) begin
          st = StatusEmpty;
        end else begin
          do_remove = (req_mode_q == ModePop);
        end
      end
      ModeRemoveId, ModeFindId: begin
        if (is_none) begin
          st = StatusEmpty;
        end else if (!hit_any) begin
          st = StatusNotFound;
        end else begin
          rd_idx    = hit_pos;
          r_pos     = hit_pos;
          do_remove = (req_mode_q == ModeRemoveId);
        end
      end
      ModeRemovePos: begin
        if (is_none) begin
          st = StatusEmpty;
        end else if (!pos_ok) begin
          st = StatusRange;
        end else begin
          rd_idx    = PosW'(req_pos_q);
          r_pos     = PosW'(req_pos_q);
          do_remove = 1'b1;
        end
      end
      default: st = StatusOk;
    endcase
  end

  assign rm_idx = rd_idx;

  // One read mux serves pop, peek and the id and position modes; a push reports the request itself.
  always_comb begin
    r_id    = '0;
    r_stamp = '0;
    if (do_push) begin
      r_id    = req_id_q;
      r_stamp = req_stamp_q;
    end else if (st == StatusOk && req_mode_q <= ModePeek) begin
      r_id    = cell_id[rd_idx];
      r_stamp = cell_stamp[rd_idx];
    end
  end

  always_comb begin
    count_d = count_q;
    if (exec_fire && do_push) begin
      count_d = count_q + CntW'(1);
    end else if (exec_fire && do_remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      cell_ctrl[i].shift = exec_fire && do_remove && (PosW'(i) >= rm_idx);
      cell_ctrl[i].load  = exec_fire && do_push && (count_q == CntW'(i));
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_mode_q  <= mode_i;
      req_id_q    <= req_id_i;
      req_stamp_q <= arrival_stamp_i;
      req_pos_q   <= position_i;
      hit_q       <= hit_d;
    end
    if (exec_fire) begin
      out_status_q <= st;
      out_id_q     <= r_id;
      out_stamp_q  <= r_stamp;
      out_pos_q    <= (st == StatusOk) ? PosFieldW'(r_pos) : '0;
      out_count_q  <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_id_o       = out_id_q;
  assign out_stamp_o    = out_stamp_q;
  assign out_position_o = out_pos_q;
  assign entry_count_o  = CntFieldW'(out_count_q);
  assign is_empty_o     = (out_count_q == '0);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RQF_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(Depth))
  `RQF_ASSERT_NEVER(a_hit_in_range, clk_i, rst_ni,
                    (state_q == StExec) && ((hit_q >> count_q) != '0))
  `RQF_ASSERT(a_exec_gives_result, clk_i, rst_ni, exec_fire |=> out_valid_q)
  `RQF_ASSERT(a_count_only_on_exec, clk_i, rst_ni, !exec_fire |=> $stable(count_q))

endmodule
